@@ hw/rtl/ill_pkg.sv @@
// Shared types, constants and helpers for the indexed linked list manager.
// Used by every module of the block except ill_ram; depends on nothing else.
`default_nettype none

package ill_pkg;

   localparam int NODE_COUNT = 256;
   localparam int IDX_W      = $clog2(NODE_COUNT + 1);
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int VAL_W      = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_LOCATE = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BAD   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_NONE  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_FREE,
      S_WALK,
      S_INS_LINK,
      S_INS_FIX,
      S_REM_HEAD,
      S_REM_DEL,
      S_REM_NEXT,
      S_REM_FREE,
      S_SRCH,
      S_LOC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_slot;
      logic             wr_en;
      logic [IDX_W-1:0] wr_slot;
      logic [IDX_W-1:0] wr_data;
   } link_req_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_slot;
      logic [VAL_W-1:0] wr_data;
   } val_wr_type;

   typedef struct packed {
      logic             load;
      status_type       status;
      logic [IDX_W-1:0] index;
   } done_type;

   // Slots are numbered from 1; memory rows from 0.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] t;
      t = slot - 1'b1;
      return t[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ill_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
`default_nettype none

module ill_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ill_link_mem.sv @@
// Link memory: a RAM of next-slot links with one valid bit per row, so that a
// row never written since reset reads as its reset link. Depends on ill_pkg, ill_ram.
`default_nettype none

module ill_link_mem
   import ill_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire link_req_type     link_req,
   output logic      [IDX_W-1:0] rd_link
);

   logic [NODE_COUNT-1:0] valid_ff;
   logic                  rd_valid_ff;
   logic [IDX_W-1:0]      rd_reset_ff;
   logic [IDX_W-1:0]      rd_reset_in;
   logic [IDX_W-1:0]      ram_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;

   assign rd_addr = slot_addr(link_req.rd_slot);
   assign wr_addr = slot_addr(link_req.wr_slot);

   always_comb begin
      if (link_req.rd_slot == IDX_W'(NODE_COUNT)) begin
         rd_reset_in = '0;
      end else begin
         rd_reset_in = link_req.rd_slot + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (link_req.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[rd_addr];
      rd_reset_ff <= rd_reset_in;
   end

   ill_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODE_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (link_req.wr_en),
      .wr_addr (wr_addr),
      .wr_data (link_req.wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   assign rd_link = rd_valid_ff ? ram_data : rd_reset_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ill_ctrl.sv @@
// Command sequencer: decodes a command, walks the chain one link per cycle
// and updates the list and free-stack pointers. Depends on ill_pkg.
`default_nettype none

module ill_ctrl
   import ill_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_opcode,
   input  wire logic [IDX_W-1:0] req_position,
   input  wire logic [VAL_W-1:0] req_item_value,
   input  wire logic [IDX_W-1:0] req_slot_number,
   input  wire logic             rsp_free,
   input  wire logic [IDX_W-1:0] rd_link,
   input  wire logic [VAL_W-1:0] rd_value,
   output link_req_type          link_req,
   output val_wr_type            val_wr,
   output done_type              done
);

   state_type        state_ff, state_in;
   opcode_type       op_ff, op_in, req_op;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] free_ff, free_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] nfree_ff, nfree_in;
   logic [IDX_W-1:0] del_ff, del_in;
   status_type       stat_ff, stat_in;
   logic [IDX_W-1:0] res_ff, res_in;

   logic accept;
   logic ins_bad, ins_full, rem_bad, loc_bad;
   logic link_end, k_last;

   assign req_op   = opcode_type'(req_opcode);
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign ins_bad  = req_position > cnt_ff;
   assign ins_full = (free_ff == '0) || (free_ff > IDX_W'(NODE_COUNT));
   assign rem_bad  = (req_position >= cnt_ff) || (head_ff == '0);
   assign loc_bad  = (req_slot_number == '0) || (req_slot_number > IDX_W'(NODE_COUNT));
   assign link_end = (rd_link == '0) || (rd_link > IDX_W'(NODE_COUNT));
   assign k_last   = k_ff == IDX_W'(NODE_COUNT - 1);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_INSERT: state_in = (ins_bad || ins_full) ? S_RESP : S_INS_FREE;
                  OP_REMOVE: begin
                     if (rem_bad) begin
                        state_in = S_RESP;
                     end else if (req_position == '0) begin
                        state_in = S_REM_HEAD;
                     end else if (req_position == IDX_W'(1)) begin
                        state_in = S_REM_DEL;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_SEARCH: state_in = (head_ff == '0) ? S_RESP : S_SRCH;
                  OP_LOCATE: begin
                     if (loc_bad || head_ff == '0 || head_ff == req_slot_number) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_LOC;
                     end
                  end
               endcase
            end
         end
         S_INS_FREE: begin
            if (pos_ff == '0) begin
               state_in = S_RESP;
            end else if (pos_ff == IDX_W'(1)) begin
               state_in = S_INS_LINK;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (rem_ff == IDX_W'(1)) begin
               state_in = (op_ff == OP_INSERT) ? S_INS_LINK : S_REM_DEL;
            end
         end
         S_INS_LINK: state_in = S_INS_FIX;
         S_INS_FIX:  state_in = S_RESP;
         S_REM_HEAD: state_in = S_RESP;
         S_REM_DEL:  state_in = S_REM_NEXT;
         S_REM_NEXT: state_in = S_REM_FREE;
         S_REM_FREE: state_in = S_RESP;
         S_SRCH: begin
            if (rd_value == val_ff || link_end || k_last) begin
               state_in = S_RESP;
            end
         end
         S_LOC: begin
            if (k_last || link_end || rd_link == slot_ff) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and memory requests.
   always_comb begin
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      slot_in  = slot_ff;
      head_in  = head_ff;
      free_in  = free_ff;
      cnt_in   = cnt_ff;
      cur_in   = cur_ff;
      rem_in   = rem_ff;
      k_in     = k_ff;
      nfree_in = nfree_ff;
      del_in   = del_ff;
      stat_in  = stat_ff;
      res_in   = res_ff;

      link_req.rd_slot = cur_ff;
      link_req.wr_en   = 1'b0;
      link_req.wr_slot = cur_ff;
      link_req.wr_data = free_ff;
      val_wr.wr_en     = 1'b0;
      val_wr.wr_slot   = free_ff;
      val_wr.wr_data   = val_ff;
      done.load        = 1'b0;
      done.status      = stat_ff;
      done.index       = res_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               pos_in  = req_position;
               val_in  = req_item_value;
               slot_in = req_slot_number;
               stat_in = STAT_OK;
               res_in  = '0;
               cur_in  = head_ff;
               rem_in  = req_position - 1'b1;
               k_in    = '0;
               unique case (req_op)
                  OP_INSERT: begin
                     link_req.rd_slot = free_ff;
                     if (ins_bad) begin
                        stat_in = STAT_BAD;
                     end else if (ins_full) begin
                        stat_in = STAT_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     link_req.rd_slot = head_ff;
                     if (rem_bad) begin
                        stat_in = STAT_BAD;
                     end
                  end
                  OP_SEARCH: begin
                     link_req.rd_slot = head_ff;
                     if (head_ff == '0) begin
                        stat_in = STAT_NONE;
                     end
                  end
                  OP_LOCATE: begin
                     link_req.rd_slot = head_ff;
                     if (loc_bad) begin
                        stat_in = STAT_BAD;
                     end else if (head_ff != req_slot_number) begin
                        stat_in = STAT_NONE;
                     end
                  end
               endcase
            end
         end
         S_INS_FREE: begin
            nfree_in = rd_link;
            if (pos_ff == '0) begin
               link_req.wr_en   = 1'b1;
               link_req.wr_slot = free_ff;
               link_req.wr_data = head_ff;
               val_wr.wr_en     = 1'b1;
               head_in          = free_ff;
               free_in          = rd_link;
               cnt_in           = cnt_ff + 1'b1;
               res_in           = free_ff;
            end else begin
               link_req.rd_slot = head_ff;
            end
         end
         S_WALK: begin
            cur_in           = rd_link;
            rem_in           = rem_ff - 1'b1;
            link_req.rd_slot = rd_link;
         end
         S_INS_LINK: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_slot = free_ff;
            link_req.wr_data = rd_link;
            val_wr.wr_en     = 1'b1;
         end
         S_INS_FIX: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_slot = cur_ff;
            link_req.wr_data = free_ff;
            free_in          = nfree_ff;
            cnt_in           = cnt_ff + 1'b1;
            res_in           = free_ff;
         end
         S_REM_HEAD: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_slot = head_ff;
            link_req.wr_data = free_ff;
            head_in          = rd_link;
            free_in          = head_ff;
            cnt_in           = cnt_ff - 1'b1;
         end
         S_REM_DEL: begin
            del_in           = rd_link;
            link_req.rd_slot = rd_link;
         end
         S_REM_NEXT: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_slot = cur_ff;
            link_req.wr_data = rd_link;
         end
         S_REM_FREE: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_slot = del_ff;
            link_req.wr_data = free_ff;
            free_in          = del_ff;
            cnt_in           = cnt_ff - 1'b1;
         end
         S_SRCH: begin
            if (rd_value == val_ff) begin
               stat_in = STAT_OK;
               res_in  = cur_ff;
            end else if (link_end || k_last) begin
               stat_in = STAT_NONE;
            end else begin
               cur_in           = rd_link;
               k_in             = k_ff + 1'b1;
               link_req.rd_slot = rd_link;
            end
         end
         S_LOC: begin
            if (k_last || link_end) begin
               stat_in = STAT_NONE;
            end else if (rd_link == slot_ff) begin
               stat_in = STAT_OK;
               res_in  = k_ff + 1'b1;
            end else begin
               cur_in           = rd_link;
               k_in             = k_ff + 1'b1;
               link_req.rd_slot = rd_link;
            end
         end
         S_RESP: begin
            done.load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         free_ff  <= IDX_W'(1);
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         cnt_ff   <= cnt_in;
      end
      op_ff    <= op_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      slot_ff  <= slot_in;
      cur_ff   <= cur_in;
      rem_ff   <= rem_in;
      k_ff     <= k_in;
      nfree_ff <= nfree_in;
      del_ff   <= del_in;
      stat_ff  <= stat_in;
      res_ff   <= res_in;
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

`default_nettype wire

@@ hw/rtl/indexed_linked_list_manager.sv @@
// From acceptance, insert and remove walk the chain to the given position, search and locate
// walk it up to the list length, and a rejected command goes straight to the response.
// One command is in flight at a time and the block returns to idle between commands;
// a result held by rsp_ready stalls the next.
// The output register lets a new transaction be accepted while one result waits.
// Synchronous reset empties the list and rebuilds the free stack at once through per-row
// valid bits; no clearing pass is needed. Depends on ill_pkg and its modules.
`default_nettype none

module indexed_linked_list_manager
   import ill_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_opcode,
   input  wire logic [IDX_W-1:0]        req_position,
   input  wire logic signed [VAL_W-1:0] req_item_value,
   input  wire logic [IDX_W-1:0]        req_slot_number,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [IDX_W-1:0]             rsp_result_index
);

   link_req_type     link_req;
   val_wr_type       val_wr;
   done_type         done;
   logic [IDX_W-1:0] rd_link;
   logic [VAL_W-1:0] rd_value;
   logic             rsp_free;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   ill_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_item_value  (VAL_W'(req_item_value)),
      .req_slot_number (req_slot_number),
      .rsp_free        (rsp_free),
      .rd_link         (rd_link),
      .rd_value        (rd_value),
      .link_req        (link_req),
      .val_wr          (val_wr),
      .done            (done)
   );

   ill_link_mem u_link_mem (
      .clock    (clock),
      .reset    (reset),
      .link_req (link_req),
      .rd_link  (rd_link)
   );

   ill_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NODE_COUNT)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr.wr_en),
      .wr_addr (slot_addr(val_wr.wr_slot)),
      .wr_data (val_wr.wr_data),
      .rd_addr (slot_addr(link_req.rd_slot)),
      .rd_data (rd_value)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (done.load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done.status;
         rsp_index_in  = done.index;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;

endmodule

`default_nettype wire
